FILE: rtl/core/assert_macros.svh
// assertion macros shared by the decoder rtl
// depends on signals named clk and rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked out of reset
`define GLZW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication form
`define GLZW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/glzw_pkg.sv
// shared types, codes and helpers of the gif lzw pixel decoder
// no dependencies
package glzw_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
  localparam int ACC_BITS      = MAX_CODE_BITS + 8;
  localparam int DICT_W        = MAX_CODE_BITS + 8;

  // request kinds
  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_PUSH    = 2'd1;
  localparam logic [1:0] KIND_PULL    = 2'd2;

  // response status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_PIXEL    = 3'd1;
  localparam logic [2:0] STS_NEED     = 3'd2;
  localparam logic [2:0] STS_REFUSED  = 3'd3;
  localparam logic [2:0] STS_FINISHED = 3'd4;
  localparam logic [2:0] STS_CORRUPT  = 3'd5;

  typedef enum logic [1:0] {
    RUN_GO,
    RUN_DONE,
    RUN_BAD
  } run_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_WALK_DATA,
    S_POP_REQ,
    S_POP,
    S_RESP
  } state_t;

  // first free code after a table restart
  function automatic logic [MAX_CODE_BITS:0] first_code(input logic [3:0] root);
    first_code = (MAX_CODE_BITS+1)'(1) << root;
    first_code = first_code + (MAX_CODE_BITS+1)'(2);
  endfunction

  // code count reached at a given width
  function automatic logic [MAX_CODE_BITS:0] limit_code(input logic [3:0] width);
    limit_code = (MAX_CODE_BITS+1)'(1) << width;
  endfunction

endpackage

FILE: rtl/core/glzw_if.sv
// request and response channel interfaces of the decoder
// depends on glzw_pkg
interface glzw_req_if;
  import glzw_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface glzw_rsp_if;
  import glzw_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] pixel_index;
  logic [3:0] code_width;
  modport source (output valid, status, pixel_index, code_width, input ready);
  modport sink (input valid, status, pixel_index, code_width, output ready);
endinterface

FILE: rtl/core/glzw_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/core/gif_lzw_pixel_decoder_unit.sv
// gif lzw pixel decoder top level: control, bit accumulator, dictionary and stack
// depends on glzw_pkg, glzw_req_if, glzw_rsp_if, glzw_ram, assert_macros.svh
//
// channel  | dir | payload                              | request means
// ---------+-----+--------------------------------------+--------------------------
// req      | in  | kind[1:0], value[7:0]                | restart, push byte, pull
// rsp      | out | status[2:0], pixel_index, code_width | one answer per request
//
// one request at a time; restart, push, unknown kinds and a pull after the run ends: accept, then answer
// a pull with a non-empty stack: accept, stack read, answer
// an empty-stack pull: accept, a decode step per code taken, a walk and a data step per dictionary entry
// walked (dictionary ram read), a walk step for the root byte, stack read request and pop, answer
// synchronous reset clears control only; the rams need no clearing pass
// the answer waits in its register while rsp.ready is low; req.ready stays low meanwhile
module gif_lzw_pixel_decoder_unit (
  input logic clk,
  input logic rst,
  glzw_req_if.sink   req,
  glzw_rsp_if.source rsp
);
  import glzw_pkg::*;

  localparam int AW = MAX_CODE_BITS;

  state_t state, state_next;
  run_t   run_state, run_state_next;

  logic [ACC_BITS-1:0] bit_accumulator, bit_accumulator_next;
  logic [4:0]          bits_held, bits_held_next;
  logic [7:0]          subblock_bytes_left, subblock_bytes_left_next;
  logic                data_ended, data_ended_next;
  logic [3:0]          root_size, root_size_next;
  logic [3:0]          width_now, width_now_next;
  logic [AW:0]         next_free_code, next_free_code_next;
  logic [AW:0]         width_limit_code, width_limit_code_next;
  logic [AW-1:0]       previous_code, previous_code_next;
  logic [7:0]          previous_first_char, previous_first_char_next;
  logic                previous_valid, previous_valid_next;
  logic [AW:0]         stack_depth, stack_depth_next;
  logic [AW-1:0]       walk, walk_next;
  logic [AW-1:0]       cur_code, cur_code_next;
  logic [2:0]          status, status_next;
  logic [7:0]          pixel, pixel_next;

  // memory ports
  logic              dict_we, dict_re;
  logic [AW-1:0]     dict_waddr, dict_raddr;
  logic [DICT_W-1:0] dict_wdata, dict_rdata;
  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata, stk_rdata;

  // decode helpers
  logic            accept;
  logic [AW:0]     clr_code, first_free;
  logic [AW-1:0]   code;
  logic            have_bits, is_clear, is_end, is_kwk, is_bad, walk_in_table;
  logic [AW:0]     depth_dec;

  assign accept     = req.valid && req.ready;
  assign clr_code   = (AW+1)'(1) << root_size;
  assign first_free = first_code(root_size);
  assign have_bits  = {1'b0, bits_held} >= {2'b0, width_now};
  assign code       = AW'(bit_accumulator & ((ACC_BITS'(1) << width_now) - ACC_BITS'(1)));
  assign is_clear   = {1'b0, code} == clr_code;
  assign is_end     = {1'b0, code} == clr_code + (AW+1)'(1);
  assign is_kwk     = ({1'b0, code} == next_free_code) && previous_valid;
  assign is_bad     = ({1'b0, code} >= next_free_code) && !is_kwk;
  assign walk_in_table = {1'b0, walk} >= first_free;
  assign depth_dec  = stack_depth - (AW+1)'(1);

  // prefix in the upper bits, suffix in the low byte
  glzw_ram #(.WIDTH(DICT_W), .DEPTH(TABLE_DEPTH)) u_dict (
    .clk, .we(dict_we), .waddr(dict_waddr), .wdata(dict_wdata),
    .re(dict_re), .raddr(dict_raddr), .rdata(dict_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = state == S_RESP;
  assign rsp.status      = status;
  assign rsp.pixel_index = pixel;
  assign rsp.code_width  = width_now;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.kind == KIND_PULL && run_state == RUN_GO) begin
            state_next = (stack_depth != '0) ? S_POP : S_DECODE;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_DECODE: begin
        if (!have_bits || is_end || is_bad) begin
          state_next = S_RESP;
        end else if (!is_clear) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_in_table) begin
          state_next = S_WALK_DATA;
        end else begin
          state_next = stack_depth[AW] ? S_RESP : S_POP_REQ;
        end
      end
      S_WALK_DATA: state_next = stack_depth[AW] ? S_RESP : S_WALK;
      S_POP_REQ:   state_next = S_POP;
      S_POP:       state_next = S_RESP;
      S_RESP:      state_next = rsp.ready ? S_IDLE : S_RESP;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    logic [3:0]  root_v;
    logic [AW:0] nfc_v;
    bit_accumulator_next     = bit_accumulator;
    bits_held_next           = bits_held;
    subblock_bytes_left_next = subblock_bytes_left;
    data_ended_next          = data_ended;
    root_size_next           = root_size;
    width_now_next           = width_now;
    next_free_code_next      = next_free_code;
    width_limit_code_next    = width_limit_code;
    previous_code_next       = previous_code;
    previous_first_char_next = previous_first_char;
    previous_valid_next      = previous_valid;
    run_state_next           = run_state;
    stack_depth_next         = stack_depth;
    walk_next                = walk;
    cur_code_next            = cur_code;
    status_next              = status;
    pixel_next               = pixel;
    dict_we    = 1'b0;
    dict_waddr = next_free_code[AW-1:0];
    dict_wdata = {previous_code, walk[7:0]};
    dict_re    = 1'b0;
    dict_raddr = walk;
    stk_we     = 1'b0;
    stk_waddr  = stack_depth[AW-1:0];
    stk_wdata  = walk[7:0];
    stk_re     = 1'b0;
    stk_raddr  = depth_dec[AW-1:0];
    root_v     = 4'd2;
    nfc_v      = next_free_code;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pixel_next = 8'd0;
          case (req.kind)
            KIND_RESTART: begin
              if (req.value < 8'd2) begin
                root_v = 4'd2;
              end else if (req.value > 8'd8) begin
                root_v = 4'd8;
              end else begin
                root_v = req.value[3:0];
              end
              root_size_next           = root_v;
              bit_accumulator_next     = '0;
              bits_held_next           = '0;
              subblock_bytes_left_next = '0;
              data_ended_next          = 1'b0;
              run_state_next           = RUN_GO;
              stack_depth_next         = '0;
              width_now_next           = root_v + 4'd1;
              next_free_code_next      = first_code(root_v);
              width_limit_code_next    = limit_code(root_v + 4'd1);
              previous_valid_next      = 1'b0;
              previous_code_next       = '0;
              previous_first_char_next = '0;
              status_next              = STS_OK;
            end
            KIND_PUSH: begin
              status_next = STS_OK;
              if (data_ended) begin
                status_next = STS_REFUSED;
              end else if (run_state != RUN_GO) begin
                status_next = STS_OK;
              end else if (subblock_bytes_left == '0) begin
                // length byte, zero closes the data
                if (req.value == 8'd0) begin
                  data_ended_next = 1'b1;
                end else begin
                  subblock_bytes_left_next = req.value;
                end
              end else if (bits_held > 5'(ACC_BITS - 8)) begin
                status_next = STS_REFUSED;
              end else begin
                bit_accumulator_next = bit_accumulator |
                                       (ACC_BITS'(req.value) << bits_held);
                bits_held_next           = bits_held + 5'd8;
                subblock_bytes_left_next = subblock_bytes_left - 8'd1;
              end
            end
            KIND_PULL: begin
              if (run_state == RUN_DONE) begin
                status_next = STS_FINISHED;
              end else if (run_state == RUN_BAD) begin
                status_next = STS_CORRUPT;
              end else begin
                stk_re = stack_depth != '0;
              end
            end
            default: status_next = STS_REFUSED;
          endcase
        end
      end
      S_DECODE: begin
        pixel_next = 8'd0;
        if (!have_bits) begin
          if (data_ended) begin
            run_state_next = RUN_DONE;
            status_next    = STS_FINISHED;
          end else begin
            status_next = STS_NEED;
          end
        end else begin
          bit_accumulator_next = bit_accumulator >> width_now;
          bits_held_next       = bits_held - {1'b0, width_now};
          if (is_clear) begin
            width_now_next           = root_size + 4'd1;
            next_free_code_next      = first_free;
            width_limit_code_next    = limit_code(root_size + 4'd1);
            previous_valid_next      = 1'b0;
            previous_code_next       = '0;
            previous_first_char_next = '0;
          end else if (is_end) begin
            run_state_next = RUN_DONE;
            status_next    = STS_FINISHED;
          end else if (is_bad) begin
            run_state_next   = RUN_BAD;
            stack_depth_next = '0;
            status_next      = STS_CORRUPT;
          end else begin
            cur_code_next = code;
            if (is_kwk) begin
              // code not yet in the table: repeat the previous first byte
              stk_we           = 1'b1;
              stk_wdata        = previous_first_char;
              stack_depth_next = stack_depth + (AW+1)'(1);
              walk_next        = previous_code;
            end else begin
              walk_next = code;
            end
          end
        end
      end
      S_WALK: begin
        if (walk_in_table) begin
          dict_re = 1'b1;
        end else if (stack_depth[AW]) begin
          run_state_next   = RUN_BAD;
          stack_depth_next = '0;
          status_next      = STS_CORRUPT;
        end else begin
          // root byte ends the chain, then the table grows if previous_valid and below the limit
          stk_we           = 1'b1;
          stk_wdata        = walk[7:0];
          stack_depth_next = stack_depth + (AW+1)'(1);
          if (next_free_code < width_limit_code && previous_valid) begin
            dict_we = 1'b1;
            nfc_v   = next_free_code + (AW+1)'(1);
          end
          next_free_code_next      = nfc_v;
          previous_first_char_next = walk[7:0];
          previous_code_next       = cur_code;
          previous_valid_next      = 1'b1;
          if (nfc_v >= width_limit_code && width_now < 4'(MAX_CODE_BITS)) begin
            width_limit_code_next = width_limit_code << 1;
            width_now_next        = width_now + 4'd1;
          end
        end
      end
      S_WALK_DATA: begin
        if (stack_depth[AW]) begin
          run_state_next   = RUN_BAD;
          stack_depth_next = '0;
          status_next      = STS_CORRUPT;
        end else begin
          stk_we           = 1'b1;
          stk_wdata        = dict_rdata[7:0];
          stack_depth_next = stack_depth + (AW+1)'(1);
          walk_next        = dict_rdata[DICT_W-1:8];
        end
      end
      S_POP_REQ: begin
        stk_re = 1'b1;
      end
      S_POP: begin
        stack_depth_next = depth_dec;
        pixel_next       = stk_rdata;
        status_next      = STS_PIXEL;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      run_state           <= RUN_GO;
      bit_accumulator     <= '0;
      bits_held           <= '0;
      subblock_bytes_left <= '0;
      data_ended          <= 1'b0;
      root_size           <= 4'd8;
      width_now           <= 4'd9;
      next_free_code      <= first_code(4'd8);
      width_limit_code    <= limit_code(4'd9);
      previous_code       <= '0;
      previous_first_char <= '0;
      previous_valid      <= 1'b0;
      stack_depth         <= '0;
    end else begin
      state               <= state_next;
      run_state           <= run_state_next;
      bit_accumulator     <= bit_accumulator_next;
      bits_held           <= bits_held_next;
      subblock_bytes_left <= subblock_bytes_left_next;
      data_ended          <= data_ended_next;
      root_size           <= root_size_next;
      width_now           <= width_now_next;
      next_free_code      <= next_free_code_next;
      width_limit_code    <= width_limit_code_next;
      previous_code       <= previous_code_next;
      previous_first_char <= previous_first_char_next;
      previous_valid      <= previous_valid_next;
      stack_depth         <= stack_depth_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    walk     <= walk_next;
    cur_code <= cur_code_next;
    status   <= status_next;
    pixel    <= pixel_next;
  end

  `include "assert_macros.svh"

  `GLZW_ASSERT(a_depth_bound, stack_depth <= (AW+1)'(TABLE_DEPTH), "stack depth over table size")
  `GLZW_ASSERT_IMP(a_pixel_zero, rsp.valid && status != STS_PIXEL, pixel == 8'd0, "pixel not zero")
  `GLZW_ASSERT_IMP(a_resp_done, rsp.valid && rsp.ready, ##1 req.ready, "no return to idle")
  `GLZW_ASSERT_IMP(a_nfc_limit, previous_valid, next_free_code <= width_limit_code, "table past limit")

endmodule
